FILE: rtl/core/weighted_moving_average_offset_macros.svh
// assertion macros for the weighted moving average offset block
`ifndef WEIGHTED_MOVING_AVERAGE_OFFSET_MACROS_SVH
`define WEIGHTED_MOVING_AVERAGE_OFFSET_MACROS_SVH

// same-cycle implication, checked after reset
`define WMAO_CHECK_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked after reset
`define WMAO_CHECK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/wmao_pkg.sv
// shared constants and types of the weighted moving average offset block
package wmao_pkg;

    localparam int WINDOW_MAX_DEF  = 64;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int CFG_W           = 7;
    localparam int FRAC_W          = 8;
    localparam int OUT_W           = 25;
    localparam int OUT_TW          = ((OUT_W + 7) / 8) * 8;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_DIV,
        S_WAIT,
        S_HOLD
    } t_state;

endpackage

FILE: rtl/core/wmao_ram.sv
// generic single-port-write, registered-read ram
module wmao_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/wmao_div.sv
// restoring serial divider, one quotient bit per cycle
module wmao_div #(
    parameter int NUM_W = 36,
    parameter int DEN_W = 12
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_dividend,
    input  logic [DEN_W-1:0] i_divisor,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quotient
);

    localparam int CW = $clog2(NUM_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CW-1:0]    r_cnt;
    logic [DEN_W-1:0] r_rem;
    logic [NUM_W-1:0] r_quo;
    logic [DEN_W-1:0] r_div;

    logic [DEN_W:0]   shift_in;
    logic [DEN_W+1:0] trial;
    logic             no_borrow;
    logic [DEN_W-1:0] n_rem;

    always_comb begin
        shift_in  = {r_rem, r_quo[NUM_W-1]};
        trial     = {1'b0, shift_in} - {2'b00, r_div};
        no_borrow = !trial[DEN_W+1];
        n_rem     = no_borrow ? trial[DEN_W-1:0] : shift_in[DEN_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // dividend bits shift out the top while quotient bits shift in below
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[NUM_W-2:0], no_borrow};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

FILE: rtl/core/weighted_moving_average_offset.sv
// linear weighted moving average offset: sequencer, ring, serial accumulation and divide
// a transaction reads k ring entries through the registered ram read, starts the serial divider,
//   waits for its done flag and then loads the result register
// input ready only while the sequencer idles, so a new sample waits until the last result is loaded
// the result register lets the next sample start while a result waits downstream
// reset (i_rst_n low, synchronous): state and counters cleared, window length 1, no ram clear
`include "weighted_moving_average_offset_macros.svh"

module weighted_moving_average_offset #(
    parameter int WINDOW_MAX  = wmao_pkg::WINDOW_MAX_DEF,
    parameter int SAMPLE_BITS = wmao_pkg::SAMPLE_BITS_DEF,
    localparam int IN_TW      = ((SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [wmao_pkg::CFG_W-1:0]  i_cfg_wdata,
    input  logic                        i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    input  logic [IN_TW-1:0]            i_s_axis_tdata,   // sample_luma
    output logic                        o_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    output logic [wmao_pkg::OUT_TW-1:0] o_m_axis_tdata    // luma_change
);

    localparam int AW     = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int KW     = $clog2(WINDOW_MAX + 1);
    localparam int TRI    = WINDOW_MAX * (WINDOW_MAX + 1) / 2;
    localparam int DEN_W  = $clog2(TRI + 1);
    localparam int PSUM_W = SAMPLE_BITS + KW;
    localparam int WSUM_W = SAMPLE_BITS + DEN_W;
    localparam int NUM_W  = WSUM_W + wmao_pkg::FRAC_W;
    localparam int DIFF_W = NUM_W + 1;

    wmao_pkg::t_state r_state, n_state;

    logic [wmao_pkg::CFG_W-1:0] r_window;
    logic [AW-1:0]              r_wr_slot;
    logic [KW-1:0]              r_fill;
    logic [SAMPLE_BITS-1:0]     r_sample;
    logic [KW-1:0]              r_k;
    logic [KW-1:0]              r_issue;
    logic [AW-1:0]              r_rd_addr;
    logic                       r_rd_vld;
    logic [KW-1:0]              r_acc_cnt;
    logic [PSUM_W-1:0]          r_plain;
    logic [WSUM_W-1:0]          r_wsum;
    logic [DEN_W-1:0]           r_den;
    logic                       r_out_vld;
    logic [wmao_pkg::OUT_W-1:0] r_out_data;

    logic                   in_acc;
    logic                   in_ready;
    logic                   rd_en;
    logic                   div_start;
    logic                   out_load;
    logic                   acc_last;
    logic [KW-1:0]          fill_inc;
    logic [KW-1:0]          win_eff;
    logic [KW-1:0]          k_new;
    logic [PSUM_W-1:0]      plain_add;
    logic [SAMPLE_BITS-1:0] ram_rdata;
    logic                   div_done;
    logic [NUM_W-1:0]       div_quo;
    logic signed [DIFF_W-1:0] diff;

    wmao_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (WINDOW_MAX)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (in_acc),
        .i_waddr (r_wr_slot),
        .i_wdata (i_s_axis_tdata[SAMPLE_BITS-1:0]),
        .i_raddr (r_rd_addr),
        .o_rdata (ram_rdata)
    );

    wmao_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend ({r_wsum, {wmao_pkg::FRAC_W{1'b0}}}),
        .i_divisor  (r_den),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // window after clamping, and the count of samples averaged for this transaction
    always_comb begin
        fill_inc = (r_fill == KW'(WINDOW_MAX)) ? r_fill : r_fill + 1'b1;
        if (r_window == '0) begin
            win_eff = KW'(1);
        end else if (32'(r_window) > 32'(WINDOW_MAX)) begin
            win_eff = KW'(WINDOW_MAX);
        end else begin
            win_eff = KW'(r_window);
        end
        k_new = (win_eff < fill_inc) ? win_eff : fill_inc;
    end

    // newest first: each running plain sum adds once more to the weighted sum
    always_comb begin
        plain_add = r_plain + PSUM_W'(ram_rdata);
        acc_last  = r_rd_vld && ((r_acc_cnt + KW'(1)) == r_k);
        diff      = $signed({1'b0, div_quo})
                  - $signed(DIFF_W'({r_sample, {wmao_pkg::FRAC_W{1'b0}}}));
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            wmao_pkg::S_IDLE: begin
                if (in_acc) n_state = wmao_pkg::S_READ;
            end
            wmao_pkg::S_READ: begin
                if (acc_last) n_state = wmao_pkg::S_DIV;
            end
            wmao_pkg::S_DIV: begin
                n_state = wmao_pkg::S_WAIT;
            end
            wmao_pkg::S_WAIT: begin
                if (div_done) n_state = wmao_pkg::S_HOLD;
            end
            wmao_pkg::S_HOLD: begin
                if (!r_out_vld || i_m_axis_tready) n_state = wmao_pkg::S_IDLE;
            end
            default: n_state = wmao_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        in_ready  = 1'b0;
        rd_en     = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
        unique case (r_state)
            wmao_pkg::S_IDLE: in_ready  = 1'b1;
            wmao_pkg::S_READ: rd_en     = (r_issue != r_k);
            wmao_pkg::S_DIV:  div_start = 1'b1;
            wmao_pkg::S_WAIT: ;
            wmao_pkg::S_HOLD: out_load  = !r_out_vld || i_m_axis_tready;
            default: ;
        endcase
    end

    assign in_acc = i_s_axis_tvalid && in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= wmao_pkg::S_IDLE;
            r_window  <= wmao_pkg::CFG_W'(1);
            r_wr_slot <= '0;
            r_fill    <= '0;
            r_k       <= '0;
            r_issue   <= '0;
            r_rd_addr <= '0;
            r_rd_vld  <= 1'b0;
            r_acc_cnt <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= rd_en;
            if (i_cfg_we) begin
                r_window <= i_cfg_wdata;
            end
            if (in_acc) begin
                r_wr_slot <= (r_wr_slot == AW'(WINDOW_MAX - 1)) ? '0 : r_wr_slot + 1'b1;
                r_fill    <= fill_inc;
                r_k       <= k_new;
                r_issue   <= '0;
                r_acc_cnt <= '0;
                r_rd_addr <= r_wr_slot;
            end
            if (rd_en) begin
                r_issue   <= r_issue + 1'b1;
                r_rd_addr <= (r_rd_addr == '0) ? AW'(WINDOW_MAX - 1) : r_rd_addr - 1'b1;
            end
            if (r_rd_vld) begin
                r_acc_cnt <= r_acc_cnt + 1'b1;
            end
            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_sample <= i_s_axis_tdata[SAMPLE_BITS-1:0];
            r_plain  <= '0;
            r_wsum   <= '0;
            r_den    <= '0;
        end else if (r_rd_vld) begin
            r_plain <= plain_add;
            r_wsum  <= r_wsum + WSUM_W'(plain_add);
            r_den   <= r_den + DEN_W'(r_acc_cnt) + DEN_W'(1);
        end
        if (out_load) begin
            r_out_data <= wmao_pkg::OUT_W'(diff);
        end
    end

    assign o_s_axis_tready = in_ready;
    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {{(wmao_pkg::OUT_TW - wmao_pkg::OUT_W){1'b0}}, r_out_data};

    `WMAO_CHECK_IMP(a_k_within_fill, r_state != wmao_pkg::S_IDLE,
        (r_k != '0) && (r_k <= r_fill), "averaging count outside stored samples")
    `WMAO_CHECK_IMP(a_acc_in_walk, r_rd_vld,
        (r_state == wmao_pkg::S_READ) && (r_acc_cnt < r_k), "ring data returned outside the walk")
    `WMAO_CHECK_NEXT(a_div_done_holds, div_done,
        r_state == wmao_pkg::S_HOLD, "divider finished outside its wait")

endmodule
